### rtl/lpic_pkg.sv
package lpic_pkg;

  localparam int unsigned POWER_W  = 10;
  localparam int unsigned REQPOW_W = 11;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  localparam logic [POWER_W-1:0]  MAX_POWER_RST = 10'd1000;
  localparam logic [TICKS_W-1:0]  MAX_PULSE_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd999;

  // power times period, divided by 1000 through a reciprocal
  localparam int unsigned PROD_W      = POWER_W + PERIOD_W;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned FULL_W      = PROD_W + RECIP_W;
  localparam int unsigned QUOT_W      = FULL_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 3'd0,
    REQ_FIRE    = 3'd1,
    REQ_DISABLE = 3'd2,
    REQ_OPEN    = 3'd3,
    REQ_CLOSE   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    REG_MAX_POWER = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_PERIOD    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    DUTY_KEEP,
    DUTY_ZERO,
    DUTY_LOAD
  } duty_act_e;

  typedef struct packed {
    logic                 accepted;
    logic                 laser_enable;
    logic                 shutter_level;
    logic                 timed_out;
    logic [POWER_W-1:0]   applied_power;
    logic [TIME_W-1:0]    last_fire_time;
    duty_act_e            duty_act;
    logic [PROD_W-1:0]    product;
    logic [PERIOD_W-1:0]  period;
  } mid_t;

endpackage

### rtl/laser_pulse_interlock_controller.sv
// channel   direction  handshake                fields
// in        slave      in_valid_i / in_stall_o  req_type, interlock_ok, power_tenths,
//                                               pulse_ticks
// out       master     out_valid_o / out_stall_i accepted, laser_enable, shutter_level,
//                                               duty_count, timed_out, applied_power,
//                                               last_fire_time
// cfg       apb slave  psel, penable, pready    max_power_tenths, max_pulse_ticks,
//                                               pwm_period
//
// one event per cycle unless the output stalls; results pass the input register,
// then state update and power product, then reciprocal divide into the result register
// the state loop holds only the state registers; the duty path is two multiplies deep
// reset clears valids, control state and duty register, config registers to defaults
// a stall holds the output register; bubbles in the pipe still take new events
module laser_pulse_interlock_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lpic_pkg::REQ_W-1:0]          req_type_i,
  input  logic                                interlock_ok_i,
  input  logic signed [lpic_pkg::REQPOW_W-1:0] power_tenths_i,
  input  logic [lpic_pkg::TICKS_W-1:0]        pulse_ticks_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic                                laser_enable_o,
  output logic                                shutter_level_o,
  output logic [lpic_pkg::PERIOD_W-1:0]       duty_count_o,
  output logic                                timed_out_o,
  output logic [lpic_pkg::POWER_W-1:0]        applied_power_o,
  output logic [lpic_pkg::TIME_W-1:0]         last_fire_time_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpic_pkg::ADDR_W-1:0]         paddr,
  input  logic [lpic_pkg::DATA_W-1:0]         pwdata,
  output logic [lpic_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  // configuration registers
  logic [lpic_pkg::POWER_W-1:0]  max_power_q;
  logic [lpic_pkg::TICKS_W-1:0]  max_pulse_q;
  logic [lpic_pkg::PERIOD_W-1:0] period_q;
  lpic_pkg::reg_idx_e            reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = lpic_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q <= lpic_pkg::MAX_POWER_RST;
      max_pulse_q <= lpic_pkg::MAX_PULSE_RST;
      period_q    <= lpic_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lpic_pkg::REG_MAX_POWER: max_power_q <= pwdata[lpic_pkg::POWER_W-1:0];
        lpic_pkg::REG_MAX_PULSE: max_pulse_q <= pwdata[lpic_pkg::TICKS_W-1:0];
        lpic_pkg::REG_PERIOD:    period_q    <= pwdata[lpic_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lpic_pkg::REG_MAX_POWER:
        prdata = {{(lpic_pkg::DATA_W-lpic_pkg::POWER_W){1'b0}}, max_power_q};
      lpic_pkg::REG_MAX_PULSE:
        prdata = {{(lpic_pkg::DATA_W-lpic_pkg::TICKS_W){1'b0}}, max_pulse_q};
      lpic_pkg::REG_PERIOD:
        prdata = {{(lpic_pkg::DATA_W-lpic_pkg::PERIOD_W){1'b0}}, period_q};
      default:
        prdata = '0;
    endcase
  end

  // pipeline flow
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic adv_in, adv_mid, adv_out;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_mid    = !mid_valid_q || adv_out;
  assign adv_in     = !in_valid_q || adv_mid;
  assign in_stall_o = !adv_in;

  // input register
  logic [lpic_pkg::REQ_W-1:0]           req_q;
  logic                                 ilk_q;
  logic signed [lpic_pkg::REQPOW_W-1:0] pow_q;
  logic [lpic_pkg::TICKS_W-1:0]         dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      req_q <= req_type_i;
      ilk_q <= interlock_ok_i;
      pow_q <= power_tenths_i;
      dur_q <= pulse_ticks_i;
    end
  end

  // control state
  logic                          active_q, active_d;
  logic                          shutter_q, shutter_d;
  logic [lpic_pkg::TICKS_W-1:0]  ticks_left_q, ticks_left_d;
  logic [lpic_pkg::TIME_W-1:0]   now_q, now_d;
  logic [lpic_pkg::TIME_W-1:0]   fire_time_q, fire_time_d;
  logic [lpic_pkg::POWER_W-1:0]  last_power_q, last_power_d;
  logic [lpic_pkg::POWER_W-1:0]  pw;
  logic [lpic_pkg::TICKS_W-1:0]  dur_lim;
  lpic_pkg::mid_t                mid_d, mid_q;
  logic                          step;

  assign step = in_valid_q && adv_mid;

  always_comb begin
    active_d     = active_q;
    shutter_d    = shutter_q;
    ticks_left_d = ticks_left_q;
    now_d        = now_q;
    fire_time_d  = fire_time_q;
    last_power_d = last_power_q;
    mid_d.accepted  = 1'b0;
    mid_d.timed_out = 1'b0;
    mid_d.duty_act  = lpic_pkg::DUTY_KEEP;

    // negative requests clamp to zero, then to the limit
    if (pow_q[lpic_pkg::REQPOW_W-1]) begin
      pw = '0;
    end else if (pow_q[lpic_pkg::POWER_W-1:0] > max_power_q) begin
      pw = max_power_q;
    end else begin
      pw = pow_q[lpic_pkg::POWER_W-1:0];
    end

    dur_lim = (dur_q > max_pulse_q) ? max_pulse_q : dur_q;
    if (dur_lim == '0) begin
      dur_lim = {{(lpic_pkg::TICKS_W-1){1'b0}}, 1'b1};
    end

    unique case (lpic_pkg::req_e'(req_q))
      lpic_pkg::REQ_TICK: begin
        mid_d.accepted = 1'b1;
        now_d = now_q + 1'b1;
        if (active_q) begin
          if (ticks_left_q <= {{(lpic_pkg::TICKS_W-1){1'b0}}, 1'b1}) begin
            active_d        = 1'b0;
            shutter_d       = 1'b0;
            ticks_left_d    = '0;
            mid_d.duty_act  = lpic_pkg::DUTY_ZERO;
            mid_d.timed_out = 1'b1;
          end else begin
            ticks_left_d = ticks_left_q - 1'b1;
          end
        end
      end
      lpic_pkg::REQ_FIRE: begin
        if (ilk_q) begin
          mid_d.accepted = 1'b1;
          shutter_d      = 1'b1;
          last_power_d   = pw;
          fire_time_d    = now_q;
          ticks_left_d   = dur_lim;
          active_d       = 1'b1;
          mid_d.duty_act = lpic_pkg::DUTY_LOAD;
        end
      end
      lpic_pkg::REQ_DISABLE: begin
        mid_d.accepted = 1'b1;
        active_d       = 1'b0;
        shutter_d      = 1'b0;
        ticks_left_d   = '0;
        mid_d.duty_act = lpic_pkg::DUTY_ZERO;
      end
      lpic_pkg::REQ_OPEN: begin
        if (ilk_q) begin
          mid_d.accepted = 1'b1;
          shutter_d      = 1'b1;
        end
      end
      lpic_pkg::REQ_CLOSE: begin
        mid_d.accepted = 1'b1;
        shutter_d      = 1'b0;
      end
      default: ;
    endcase

    mid_d.laser_enable   = active_d;
    mid_d.shutter_level  = shutter_d;
    mid_d.applied_power  = last_power_d;
    mid_d.last_fire_time = fire_time_d;
    mid_d.product        = pw * period_q;
    mid_d.period         = period_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      shutter_q    <= 1'b0;
      ticks_left_q <= '0;
      now_q        <= '0;
      fire_time_q  <= '0;
      last_power_q <= '0;
      mid_valid_q  <= 1'b0;
    end else begin
      if (adv_mid) begin
        mid_valid_q <= in_valid_q;
      end
      if (step) begin
        active_q     <= active_d;
        shutter_q    <= shutter_d;
        ticks_left_q <= ticks_left_d;
        now_q        <= now_d;
        fire_time_q  <= fire_time_d;
        last_power_q <= last_power_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      mid_q <= mid_d;
    end
  end

  // divide by 1000 and saturate at the period
  logic [lpic_pkg::FULL_W-1:0]   duty_full;
  logic [lpic_pkg::QUOT_W-1:0]   duty_quot;
  logic [lpic_pkg::PERIOD_W-1:0] duty_new, duty_q, duty_d;

  assign duty_full = mid_q.product * lpic_pkg::RECIP_1000;
  assign duty_quot = duty_full[lpic_pkg::FULL_W-1:lpic_pkg::RECIP_SHIFT];

  always_comb begin
    if (duty_quot > {{(lpic_pkg::QUOT_W-lpic_pkg::PERIOD_W){1'b0}}, mid_q.period}) begin
      duty_new = mid_q.period;
    end else begin
      duty_new = duty_quot[lpic_pkg::PERIOD_W-1:0];
    end
    unique case (mid_q.duty_act)
      lpic_pkg::DUTY_ZERO: duty_d = '0;
      lpic_pkg::DUTY_LOAD: duty_d = duty_new;
      default:             duty_d = duty_q;
    endcase
  end

  // result register; the duty register is both state and output field
  logic                         acc_q, en_q, shut_out_q, tout_q;
  logic [lpic_pkg::POWER_W-1:0] pow_out_q;
  logic [lpic_pkg::TIME_W-1:0]  ftime_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else if (adv_out) begin
      out_valid_q <= mid_valid_q;
      if (mid_valid_q) begin
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && mid_valid_q) begin
      acc_q       <= mid_q.accepted;
      en_q        <= mid_q.laser_enable;
      shut_out_q  <= mid_q.shutter_level;
      tout_q      <= mid_q.timed_out;
      pow_out_q   <= mid_q.applied_power;
      ftime_out_q <= mid_q.last_fire_time;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign laser_enable_o   = en_q;
  assign shutter_level_o  = shut_out_q;
  assign duty_count_o     = duty_q;
  assign timed_out_o      = tout_q;
  assign applied_power_o  = pow_out_q;
  assign last_fire_time_o = ftime_out_q;

`ifndef NO_ASSERTIONS
  a_active_has_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ticks_left_q != '0)
    else $error("pulse running with no ticks left");

  a_idle_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !laser_enable_o |-> duty_count_o == '0)
    else $error("duty applied while laser disabled");

  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timed_out_o |-> !laser_enable_o && !shutter_level_o && accepted_o)
    else $error("timeout left laser or shutter on");
`endif

endmodule

### bench/laser_pulse_interlock_controller_tb.sv
module laser_pulse_interlock_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_GAP   = 6;

  // request codes with no meaning, which the block ignores
  localparam logic [lpic_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [lpic_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                          accepted;
    logic                          laser_enable;
    logic                          shutter_level;
    logic [lpic_pkg::PERIOD_W-1:0] duty_count;
    logic                          timed_out;
    logic [lpic_pkg::POWER_W-1:0]  applied_power;
    logic [lpic_pkg::TIME_W-1:0]   last_fire_time;
  } status_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [lpic_pkg::REQ_W-1:0]           req_type_i = lpic_pkg::REQ_TICK;
  logic                                 interlock_ok_i = 1'b0;
  logic signed [lpic_pkg::REQPOW_W-1:0] power_tenths_i = '0;
  logic [lpic_pkg::TICKS_W-1:0]         pulse_ticks_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic                                 accepted_o;
  logic                                 laser_enable_o;
  logic                                 shutter_level_o;
  logic [lpic_pkg::PERIOD_W-1:0]        duty_count_o;
  logic                                 timed_out_o;
  logic [lpic_pkg::POWER_W-1:0]         applied_power_o;
  logic [lpic_pkg::TIME_W-1:0]          last_fire_time_o;
  logic                                 psel = 1'b0;
  logic                                 penable = 1'b0;
  logic                                 pwrite = 1'b0;
  logic [lpic_pkg::ADDR_W-1:0]          paddr = '0;
  logic [lpic_pkg::DATA_W-1:0]          pwdata = '0;
  logic [lpic_pkg::DATA_W-1:0]          prdata;
  logic                                 pready;

  laser_pulse_interlock_controller DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .interlock_ok_i   (interlock_ok_i),
    .power_tenths_i   (power_tenths_i),
    .pulse_ticks_i    (pulse_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .laser_enable_o   (laser_enable_o),
    .shutter_level_o  (shutter_level_o),
    .duty_count_o     (duty_count_o),
    .timed_out_o      (timed_out_o),
    .applied_power_o  (applied_power_o),
    .last_fire_time_o (last_fire_time_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the controller
  logic                          pulse_on;
  logic                          shutter_up;
  int unsigned                   pulse_left;
  logic [lpic_pkg::TIME_W-1:0]   tick_count;
  logic [lpic_pkg::TIME_W-1:0]   fire_stamp;
  int unsigned                   power_held;
  int unsigned                   duty_held;
  int unsigned                   cfg_max_power;
  int unsigned                   cfg_max_pulse;
  int unsigned                   cfg_period;

  status_t     status_q[$];
  status_t     want;
  status_t     got;
  int unsigned errors;
  int unsigned stuck_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        long_hold;
  event        hold_ev;

  function automatic void end_pulse();
    pulse_on   = 1'b0;
    duty_held  = 0;
    shutter_up = 1'b0;
    pulse_left = 0;
  endfunction

  function automatic status_t next_status(logic [lpic_pkg::REQ_W-1:0] req, logic ilk,
                                          logic signed [lpic_pkg::REQPOW_W-1:0] pw_req,
                                          logic [lpic_pkg::TICKS_W-1:0] dur_req);
    status_t     s;
    int unsigned pw;
    int unsigned dur;
    int unsigned duty;
    s = '0;
    case (req)
      lpic_pkg::REQ_TICK: begin
        s.accepted = 1'b1;
        tick_count = tick_count + 32'd1;
        if (pulse_on) begin
          if (pulse_left <= 1) begin
            end_pulse();
            s.timed_out = 1'b1;
          end else begin
            pulse_left = pulse_left - 1;
          end
        end
      end
      lpic_pkg::REQ_FIRE: begin
        if (ilk) begin
          s.accepted = 1'b1;
          shutter_up = 1'b1;
          if (pw_req < 0) pw = 0;
          else            pw = 32'(pw_req[lpic_pkg::REQPOW_W-2:0]);
          if (pw > cfg_max_power) pw = cfg_max_power;
          dur = 32'(dur_req);
          if (dur > cfg_max_pulse) dur = cfg_max_pulse;
          if (dur == 0) dur = 1;
          duty = pw * cfg_period / 1000;
          if (duty > cfg_period) duty = cfg_period;
          duty_held  = duty;
          power_held = pw;
          fire_stamp = tick_count;
          pulse_left = dur;
          pulse_on   = 1'b1;
        end
      end
      lpic_pkg::REQ_DISABLE: begin
        s.accepted = 1'b1;
        end_pulse();
      end
      lpic_pkg::REQ_OPEN: begin
        if (ilk) begin
          s.accepted = 1'b1;
          shutter_up = 1'b1;
        end
      end
      lpic_pkg::REQ_CLOSE: begin
        s.accepted = 1'b1;
        shutter_up = 1'b0;
      end
      default: ;
    endcase
    s.laser_enable   = pulse_on;
    s.shutter_level  = shutter_up;
    s.duty_count     = duty_held[lpic_pkg::PERIOD_W-1:0];
    s.applied_power  = power_held[lpic_pkg::POWER_W-1:0];
    s.last_fire_time = fire_stamp;
    return s;
  endfunction

  task automatic send_event(logic [lpic_pkg::REQ_W-1:0] req, logic ilk,
                            logic signed [lpic_pkg::REQPOW_W-1:0] pw,
                            logic [lpic_pkg::TICKS_W-1:0] dur);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    interlock_ok_i <= ilk;
    power_tenths_i <= pw;
    pulse_ticks_i  <= dur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    status_q.push_back(next_status(req, ilk, pw, dur));
  endtask

  task automatic send_random();
    int unsigned                          pick;
    int unsigned                          r;
    logic [lpic_pkg::REQ_W-1:0]           req;
    logic                                 ilk;
    logic signed [lpic_pkg::REQPOW_W-1:0] pw;
    logic [lpic_pkg::TICKS_W-1:0]         dur;
    pick = $urandom_range(99);
    r    = $urandom_range(REQ_SPARE_HI, REQ_SPARE_LO);
    if (pick < 45)      req = lpic_pkg::REQ_TICK;
    else if (pick < 72) req = lpic_pkg::REQ_FIRE;
    else if (pick < 77) req = lpic_pkg::REQ_DISABLE;
    else if (pick < 86) req = lpic_pkg::REQ_OPEN;
    else if (pick < 97) req = lpic_pkg::REQ_CLOSE;
    else                req = r[lpic_pkg::REQ_W-1:0];
    ilk = ($urandom_range(99) < 85);
    if ($urandom_range(99) < 30) r = $urandom_range(0, 2047);
    else                         r = $urandom_range(0, cfg_max_power);
    pw = r[lpic_pkg::REQPOW_W-1:0];
    pick = $urandom_range(99);
    if (pick < 50)      r = $urandom_range(0, 8);
    else if (pick < 80) r = $urandom_range(0, cfg_max_pulse + 2);
    else                r = $urandom_range(0, 65535);
    dur = r[lpic_pkg::TICKS_W-1:0];
    send_event(req, ilk, pw, dur);
  endtask

  task automatic drain_status();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(lpic_pkg::reg_idx_e idx, logic [lpic_pkg::DATA_W-1:0] value);
    drain_status();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lpic_pkg::REG_MAX_POWER: cfg_max_power = 32'(value[lpic_pkg::POWER_W-1:0]);
      lpic_pkg::REG_MAX_PULSE: cfg_max_pulse = 32'(value[lpic_pkg::TICKS_W-1:0]);
      lpic_pkg::REG_PERIOD:    cfg_period    = 32'(value[lpic_pkg::PERIOD_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [lpic_pkg::TIME_W-1:0] exp_v,
                             logic [lpic_pkg::TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // extremes of every field, each request kind and the refusal cases
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_event(lpic_pkg::REQ_TICK, 1'b0, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_FIRE, 1'b0, 11'sd500, 16'd10);
    send_event(lpic_pkg::REQ_OPEN, 1'b0, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_OPEN, 1'b1, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_CLOSE, 1'b1, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sd1023, 16'hFFFF);
    // restart while running, most negative power and zero length
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sh400, 16'd0);
    send_event(lpic_pkg::REQ_TICK, 1'b1, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_TICK, 1'b0, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sd500, 16'd3);
    // shutter closes but the pulse runs on
    send_event(lpic_pkg::REQ_CLOSE, 1'b0, 11'sd0, 16'd0);
    repeat (3) send_event(lpic_pkg::REQ_TICK, 1'b1, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sd999, 16'd2);
    send_event(lpic_pkg::REQ_DISABLE, 1'b0, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_TICK, 1'b1, 11'sd0, 16'd0);
    send_event(REQ_SPARE_LO, 1'b1, 11'sd100, 16'd5);
    send_event(REQ_SPARE_HI, 1'b0, -11'sd1, 16'd1);
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sd1, 16'd1);
    send_event(lpic_pkg::REQ_TICK, 1'b1, 11'sd0, 16'd0);
    send_event(lpic_pkg::REQ_FIRE, 1'b1, 11'sd1000, 16'd1000);
    send_event(lpic_pkg::REQ_FIRE, 1'b0, 11'sd200, 16'd7);
    send_event(lpic_pkg::REQ_DISABLE, 1'b1, 11'sd0, 16'd0);
  endtask

  task automatic test_setting(int unsigned max_power, int unsigned max_pulse,
                              int unsigned period, int unsigned items,
                              int unsigned idle_pct, int unsigned stall_in_pct);
    write_reg(lpic_pkg::REG_MAX_POWER, max_power);
    write_reg(lpic_pkg::REG_MAX_PULSE, max_pulse);
    write_reg(lpic_pkg::REG_PERIOD, period);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    repeat (items) send_random();
  endtask

  // receiver holds off while events keep coming, then the sender waits for all results
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    -> hold_ev;
    repeat (40) send_random();
    drain_status();
  endtask

  always begin
    @(hold_ev);
    @(negedge clk_i);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= long_hold || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {accepted_o, laser_enable_o, shutter_level_o, duty_count_o, timed_out_o,
             applied_power_o, last_fire_time_o};
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, got %p", $time, got);
      end else begin
        want = status_q.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("laser_enable", want.laser_enable, got.laser_enable);
        check_field("shutter_level", want.shutter_level, got.shutter_level);
        check_field("duty_count", want.duty_count, got.duty_count);
        check_field("timed_out", want.timed_out, got.timed_out);
        check_field("applied_power", want.applied_power, got.applied_power);
        check_field("last_fire_time", want.last_fire_time, got.last_fire_time);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("laser_pulse_interlock_controller_tb: FAIL");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    stuck_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    long_hold     = 1'b0;
    pulse_on      = 1'b0;
    shutter_up    = 1'b0;
    pulse_left    = 0;
    tick_count    = '0;
    fire_stamp    = '0;
    power_held    = 0;
    duty_held     = 0;
    cfg_max_power = 32'(lpic_pkg::MAX_POWER_RST);
    cfg_max_pulse = 32'(lpic_pkg::MAX_PULSE_RST);
    cfg_period    = 32'(lpic_pkg::PERIOD_RST);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_setting(0, 1, 0, 60, 0, 0);
    test_setting(1000, 65535, 65535, 100, 75, 0);
    test_setting(1000, 1000, 999, 80, 0, 75);
    test_setting($urandom_range(0, 1000), $urandom_range(1, 40), $urandom_range(0, 65535),
                 120, 30, 30);
    test_setting(500, 5, 1000, 100, 0, 0);
    test_setting(1, 2, 1, 80, 30, 30);
    test_backpressure();
    test_setting($urandom_range(0, 1000), $urandom_range(1, 65535),
                 $urandom_range(0, 65535), 60, 30, 30);

    drain_status();
    if (errors == 0) begin
      $display("laser_pulse_interlock_controller_tb: PASS");
    end else begin
      $display("laser_pulse_interlock_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
